// File: sv/console_terminal_registers_defines.svh
// Assertion macros used by the bound checker in ctr_checker.sv.
`ifndef CONSOLE_TERMINAL_REGISTERS_DEFINES_SVH
`define CONSOLE_TERMINAL_REGISTERS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CTR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("console register check failed");

// Next-cycle implication, disabled during reset.
`define CTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("console register check failed");

`endif

// File: sv/ctr_pkg.sv
package ctr_pkg;

   localparam logic [3:0] OP_RD_ICCS  = 4'd0;
   localparam logic [3:0] OP_RD_RXCS  = 4'd1;
   localparam logic [3:0] OP_RD_RXDB  = 4'd2;
   localparam logic [3:0] OP_RD_TXCS  = 4'd3;
   localparam logic [3:0] OP_WR_ICCS  = 4'd4;
   localparam logic [3:0] OP_WR_RXCS  = 4'd5;
   localparam logic [3:0] OP_WR_TXCS  = 4'd6;
   localparam logic [3:0] OP_WR_TXDB  = 4'd7;
   localparam logic [3:0] OP_RX_CHAR  = 4'd8;
   localparam logic [3:0] OP_RX_BREAK = 4'd9;
   localparam logic [3:0] OP_TX_DONE  = 4'd10;
   localparam logic [3:0] OP_CLK_TICK = 4'd11;

   localparam int unsigned BIT_DONE = 7;
   localparam int unsigned BIT_IE   = 6;

   localparam logic [15:0] BREAK_WORD = 16'h8000 | 16'h2000 | 16'h0400;

   localparam logic [3:0] SEL_CHAR = 4'h0;
   localparam logic [3:0] SEL_MISC = 4'hF;
   localparam logic [7:0] FN_REBOOT    = 8'd2;
   localparam logic [7:0] FN_SOFT_DONE = 8'd5;
   localparam logic [4:0] FN_LED_GROUP = 5'd1;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [15:0] write_data;
      logic [7:0]  rx_char;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        rx_int;
      logic        tx_int;
      logic        clk_int;
      logic [2:0]  led_value;
      logic        tx_start;
      logic [7:0]  tx_char;
      logic        halt_request;
      logic        reboot_request;
      logic        soft_done_request;
      logic        reserved_fault;
   } rsp_type;

   typedef struct packed {
      logic advance;
      logic halt_on_break;
   } core_ctl_type;

endpackage

// File: sv/console_terminal_registers.sv
// Console register block for receive, transmit and interval clock. Each
// request beat is one register read, one register write or one event, and
// gives exactly one response beat. A beat is captured in an input register,
// then passes through the register logic into the response register once
// that register can take it, and one beat is taken every cycle while
// the response side keeps up. The halt-on-break enable is written through
// the csr port, which is always ready; write it only while the block is idle.
module console_terminal_registers
   import ctr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic         in_valid_ff;
   req_type      in_item_ff;
   logic         out_valid_ff;
   rsp_type      out_item_ff;
   logic         halt_enable_ff;
   logic         out_open;
   core_ctl_type ctl;
   rsp_type      result;

   assign out_open      = !out_valid_ff || !rsp_stall;
   assign req_stall     = in_valid_ff && !out_open;
   assign csr_ready     = 1'b1;
   assign ctl.advance   = in_valid_ff && out_open;
   assign ctl.halt_on_break = halt_enable_ff;

   ctr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         halt_enable_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_open) begin
            out_valid_ff <= in_valid_ff;
         end
         if (csr_valid && csr_ready) begin
            halt_enable_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_payload;
      end
      if (ctl.advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

// File: sv/ctr_core.sv
module ctr_core
   import ctr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  core_ctl_type ctl,
   input  req_type      item,
   output rsp_type      result
);

   logic        rx_done_ff, rx_done_in;
   logic        rx_ie_ff, rx_ie_in;
   logic [15:0] rx_buffer_ff, rx_buffer_in;
   logic        tx_done_ff, tx_done_in;
   logic        tx_ie_ff, tx_ie_in;
   logic        clk_ie_ff, clk_ie_in;
   logic        rx_pend_ff, rx_pend_in;
   logic        tx_pend_ff, tx_pend_in;
   logic        clk_pend_ff, clk_pend_in;
   logic [2:0]  leds_ff, leds_in;
   logic [3:0]  sel;
   logic [7:0]  fn;
   logic        ie_bit;

   assign sel    = item.write_data[11:8];
   assign fn     = item.write_data[7:0];
   assign ie_bit = item.write_data[BIT_IE];

   always_comb begin
      rx_done_in   = rx_done_ff;
      rx_ie_in     = rx_ie_ff;
      rx_buffer_in = rx_buffer_ff;
      tx_done_in   = tx_done_ff;
      tx_ie_in     = tx_ie_ff;
      clk_ie_in    = clk_ie_ff;
      rx_pend_in   = rx_pend_ff;
      tx_pend_in   = tx_pend_ff;
      clk_pend_in  = clk_pend_ff;
      leds_in      = leds_ff;
      result       = '0;
      unique case (item.opcode)
         OP_RD_ICCS: begin
            result.read_data[BIT_IE] = clk_ie_ff;
         end
         OP_RD_RXCS: begin
            result.read_data[BIT_DONE] = rx_done_ff;
            result.read_data[BIT_IE]   = rx_ie_ff;
         end
         OP_RD_RXDB: begin
            result.read_data = rx_buffer_ff;
            if (rx_done_ff) begin
               rx_done_in   = 1'b0;
               rx_buffer_in = {8'h00, rx_buffer_ff[7:0]};
               rx_pend_in   = 1'b0;
            end
         end
         OP_RD_TXCS: begin
            result.read_data[BIT_DONE] = tx_done_ff;
            result.read_data[BIT_IE]   = tx_ie_ff;
         end
         OP_WR_ICCS: begin
            if (!ie_bit) begin
               clk_pend_in = 1'b0;
            end
            clk_ie_in = ie_bit;
         end
         OP_WR_RXCS: begin
            if (!ie_bit) begin
               rx_pend_in = 1'b0;
            end else if (rx_done_ff && !rx_ie_ff) begin
               rx_pend_in = 1'b1;
            end
            rx_ie_in = ie_bit;
         end
         OP_WR_TXCS: begin
            if (!ie_bit) begin
               tx_pend_in = 1'b0;
            end else if (tx_done_ff && !tx_ie_ff) begin
               tx_pend_in = 1'b1;
            end
            tx_ie_in = ie_bit;
         end
         OP_WR_TXDB: begin
            priority if (sel == SEL_CHAR) begin
               tx_done_in      = 1'b0;
               tx_pend_in      = 1'b0;
               result.tx_start = 1'b1;
               result.tx_char  = fn;
            end else if (sel == SEL_MISC) begin
               priority if (fn == FN_REBOOT) begin
                  result.reboot_request = 1'b1;
               end else if (fn == FN_SOFT_DONE) begin
                  result.soft_done_request = 1'b1;
               end else if (fn[7:3] == FN_LED_GROUP) begin
                  leds_in = ~fn[2:0];
               end else begin
                  leds_in = leds_ff;
               end
            end else begin
               result.reserved_fault = 1'b1;
            end
         end
         OP_RX_CHAR: begin
            rx_buffer_in = {8'h00, item.rx_char};
            rx_done_in   = 1'b1;
            if (rx_ie_ff) begin
               rx_pend_in = 1'b1;
            end
         end
         OP_RX_BREAK: begin
            result.halt_request = ctl.halt_on_break;
            rx_buffer_in        = BREAK_WORD;
            rx_done_in          = 1'b1;
            if (rx_ie_ff) begin
               rx_pend_in = 1'b1;
            end
         end
         OP_TX_DONE: begin
            tx_done_in = 1'b1;
            if (tx_ie_ff) begin
               tx_pend_in = 1'b1;
            end
         end
         OP_CLK_TICK: begin
            if (clk_ie_ff) begin
               clk_pend_in = 1'b1;
            end
         end
         default: begin
            result = '0;
         end
      endcase
      result.rx_int    = rx_pend_in;
      result.tx_int    = tx_pend_in;
      result.clk_int   = clk_pend_in;
      result.led_value = leds_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_done_ff   <= 1'b0;
         rx_ie_ff     <= 1'b0;
         rx_buffer_ff <= '0;
         tx_done_ff   <= 1'b1;
         tx_ie_ff     <= 1'b0;
         clk_ie_ff    <= 1'b0;
         rx_pend_ff   <= 1'b0;
         tx_pend_ff   <= 1'b0;
         clk_pend_ff  <= 1'b0;
         leds_ff      <= '0;
      end else if (ctl.advance) begin
         rx_done_ff   <= rx_done_in;
         rx_ie_ff     <= rx_ie_in;
         rx_buffer_ff <= rx_buffer_in;
         tx_done_ff   <= tx_done_in;
         tx_ie_ff     <= tx_ie_in;
         clk_ie_ff    <= clk_ie_in;
         rx_pend_ff   <= rx_pend_in;
         tx_pend_ff   <= tx_pend_in;
         clk_pend_ff  <= clk_pend_in;
         leds_ff      <= leds_in;
      end
   end

endmodule

// File: sv/ctr_checker.sv
`include "console_terminal_registers_defines.svh"

module ctr_checker
   import ctr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   `CTR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_payload))

   `CTR_ASSERT_NOW(a_char_zero, clock, reset, rsp_valid && !rsp_payload.tx_start,
                   rsp_payload.tx_char == 8'h00)

   `CTR_ASSERT_NOW(a_one_action, clock, reset, rsp_valid,
                   $countones({rsp_payload.tx_start, rsp_payload.halt_request,
                               rsp_payload.reboot_request, rsp_payload.soft_done_request,
                               rsp_payload.reserved_fault}) <= 1)

   `CTR_ASSERT_NOW(a_write_no_data, clock, reset,
                   rsp_valid && (rsp_payload.tx_start || rsp_payload.reserved_fault ||
                                 rsp_payload.reboot_request || rsp_payload.halt_request),
                   rsp_payload.read_data == 16'h0000)

   `CTR_ASSERT_NEXT(a_no_stall_idle, clock, reset, !rsp_valid && !req_valid,
                    !req_stall)

endmodule

bind console_terminal_registers ctr_checker u_ctr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// File: dv/console_terminal_registers_checker.sv
`timescale 1ns / 100ps
module console_terminal_registers_checker
   import ctr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_payload,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,
   output int unsigned failure_count,
   output int unsigned pending_count
);

   localparam int unsigned PEND_RX     = 0;
   localparam int unsigned PEND_TX     = 1;
   localparam int unsigned PEND_CLK    = 2;

   logic        halt_en;
   logic        rcv_done;
   logic        rcv_ie;
   logic [15:0] rcv_word;
   logic        xmt_done;
   logic        xmt_ie;
   logic        tick_ie;
   logic [2:0]  pend;
   logic [2:0]  led_state;

   rsp_type     expected_rsp [$];
   int unsigned failures;
   int unsigned beats_checked;

   task automatic report_mismatch(input string msg);
      $display("mismatch at response beat %0d: %s", beats_checked, msg);
      failures++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
      end
   endtask

   // advance the register state by one request and build its response
   function automatic rsp_type console_response(input req_type beat);
      rsp_type    r;
      logic [3:0] sel;
      logic [7:0] fn;
      logic       ie_bit;
      r      = '0;
      sel    = beat.write_data[11:8];
      fn     = beat.write_data[7:0];
      ie_bit = beat.write_data[BIT_IE];
      case (beat.opcode)
         OP_RD_ICCS: begin
            r.read_data[BIT_IE] = tick_ie;
         end
         OP_RD_RXCS: begin
            r.read_data[BIT_DONE] = rcv_done;
            r.read_data[BIT_IE]   = rcv_ie;
         end
         OP_RD_RXDB: begin
            r.read_data = rcv_word;
            if (rcv_done) begin
               rcv_done       = 1'b0;
               rcv_word[15:8] = '0;
               pend[PEND_RX]  = 1'b0;
            end
         end
         OP_RD_TXCS: begin
            r.read_data[BIT_DONE] = xmt_done;
            r.read_data[BIT_IE]   = xmt_ie;
         end
         OP_WR_ICCS: begin
            if (!ie_bit) pend[PEND_CLK] = 1'b0;
            tick_ie = ie_bit;
         end
         OP_WR_RXCS: begin
            if (!ie_bit) pend[PEND_RX] = 1'b0;
            else if (rcv_done && !rcv_ie) pend[PEND_RX] = 1'b1;
            rcv_ie = ie_bit;
         end
         OP_WR_TXCS: begin
            if (!ie_bit) pend[PEND_TX] = 1'b0;
            else if (xmt_done && !xmt_ie) pend[PEND_TX] = 1'b1;
            xmt_ie = ie_bit;
         end
         OP_WR_TXDB: begin
            if (sel == SEL_CHAR) begin
               xmt_done      = 1'b0;
               pend[PEND_TX] = 1'b0;
               r.tx_start    = 1'b1;
               r.tx_char     = fn;
            end else if (sel == SEL_MISC) begin
               if (fn == FN_REBOOT) r.reboot_request = 1'b1;
               else if (fn == FN_SOFT_DONE) r.soft_done_request = 1'b1;
               else if (fn[7:3] == FN_LED_GROUP) led_state = ~fn[2:0];
            end else begin
               r.reserved_fault = 1'b1;
            end
         end
         OP_RX_CHAR, OP_RX_BREAK: begin
            if (beat.opcode == OP_RX_BREAK) begin
               r.halt_request = halt_en;
               rcv_word       = BREAK_WORD;
            end else begin
               rcv_word = {8'h00, beat.rx_char};
            end
            rcv_done = 1'b1;
            if (rcv_ie) pend[PEND_RX] = 1'b1;
         end
         OP_TX_DONE: begin
            xmt_done = 1'b1;
            if (xmt_ie) pend[PEND_TX] = 1'b1;
         end
         OP_CLK_TICK: begin
            if (tick_ie) pend[PEND_CLK] = 1'b1;
         end
         default: begin
         end
      endcase
      r.rx_int    = pend[PEND_RX];
      r.tx_int    = pend[PEND_TX];
      r.clk_int   = pend[PEND_CLK];
      r.led_value = led_state;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         halt_en  = 1'b0;
         rcv_done = 1'b0;
         rcv_ie   = 1'b0;
         rcv_word = '0;
         xmt_done = 1'b1;
         xmt_ie   = 1'b0;
         tick_ie  = 1'b0;
         pend     = '0;
         led_state = '0;
         expected_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) halt_en = csr_data;
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (expected_rsp.size() == 0) begin
               report_mismatch("response beat with nothing expected");
            end else begin
               want = expected_rsp.pop_front();
               check_field("read_data", got.read_data, want.read_data);
               check_field("rx_int", 16'(got.rx_int), 16'(want.rx_int));
               check_field("tx_int", 16'(got.tx_int), 16'(want.tx_int));
               check_field("clk_int", 16'(got.clk_int), 16'(want.clk_int));
               check_field("led_value", 16'(got.led_value), 16'(want.led_value));
               check_field("tx_start", 16'(got.tx_start), 16'(want.tx_start));
               check_field("tx_char", 16'(got.tx_char), 16'(want.tx_char));
               check_field("halt_request", 16'(got.halt_request),
                           16'(want.halt_request));
               check_field("reboot_request", 16'(got.reboot_request),
                           16'(want.reboot_request));
               check_field("soft_done_request", 16'(got.soft_done_request),
                           16'(want.soft_done_request));
               check_field("reserved_fault", 16'(got.reserved_fault),
                           16'(want.reserved_fault));
            end
            beats_checked++;
         end
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(console_response(req_payload));
         end
      end
      failure_count <= failures;
      pending_count <= expected_rsp.size();
   end

endmodule

// File: dv/console_terminal_registers_test.sv
`timescale 1ns / 100ps
module console_terminal_registers_test;
   import ctr_pkg::*;

   localparam logic [3:0]  OP_UNUSED_LAST  = 4'd15;
   localparam int unsigned ITEMS_PER_PHASE = 517;
   localparam int unsigned DRAIN_CYCLES    = 8;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic        csr_data    = 1'b0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned failures;
   int unsigned pending_count;

   console_terminal_registers u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   console_terminal_registers_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .failure_count (failures),
      .pending_count (pending_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic send_beat(input logic [3:0] opcode, input logic [15:0] data,
                            input logic [7:0] ch);
      req_type beat;
      beat.opcode     = opcode;
      beat.write_data = data;
      beat.rx_char    = ch;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_halt_enable(input logic enable);
      csr_valid <= 1'b1;
      csr_data  <= enable;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // hold until every response is back, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_random(input int unsigned count);
      logic [3:0]  opcode;
      logic [15:0] data;
      logic [7:0]  ch;
      int unsigned pick;
      repeat (count) begin
         opcode = 4'($urandom_range(OP_CLK_TICK));
         if ($urandom_range(24) == 0) begin
            opcode = 4'($urandom_range(OP_UNUSED_LAST, OP_CLK_TICK + 1));
         end
         data = 16'($urandom());
         ch   = 8'($urandom());
         if (opcode == OP_WR_TXDB) begin
            pick = $urandom_range(9);
            if (pick < 4) begin
               data[11:8] = SEL_CHAR;
            end else if (pick < 8) begin
               data[11:8] = SEL_MISC;
               if (pick < 7) data[7:0] = 8'($urandom_range(15));
            end
         end
         send_beat(opcode, data, ch);
      end
   endtask

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_halt_enable(1'b0);

      send_beat(OP_RD_RXDB, 16'h0000, 8'h00);
      send_beat(OP_RD_TXCS, 16'h0000, 8'h00);
      send_beat(OP_WR_RXCS, 16'h0040, 8'h00);
      send_beat(OP_RX_CHAR, 16'h0000, 8'hFF);
      send_beat(OP_RD_RXCS, 16'h0000, 8'h00);
      send_beat(OP_RX_CHAR, 16'h0000, 8'h00);
      send_beat(OP_RD_RXDB, 16'h0000, 8'h00);
      send_beat(OP_RX_BREAK, 16'h0000, 8'h00);
      drain();
      write_halt_enable(1'b1);
      send_beat(OP_RX_BREAK, 16'h0000, 8'h00);
      send_beat(OP_RD_RXDB, 16'h0000, 8'h00);
      send_beat(OP_WR_RXCS, 16'h0000, 8'h00);
      send_beat(OP_WR_TXCS, 16'h0040, 8'h00);
      send_beat(OP_WR_TXDB, 16'h00FF, 8'h00);
      send_beat(OP_TX_DONE, 16'h0000, 8'h00);
      send_beat(OP_WR_TXDB, 16'h0F02, 8'h00);
      send_beat(OP_WR_TXDB, 16'h0F05, 8'h00);
      send_beat(OP_WR_TXDB, 16'h0F08, 8'h00);
      send_beat(OP_WR_TXDB, 16'h0F0D, 8'h00);
      send_beat(OP_WR_TXDB, 16'h0FFF, 8'h00);
      send_beat(OP_WR_TXDB, 16'hF100, 8'h00);
      send_beat(OP_WR_ICCS, 16'hFFFF, 8'h00);
      send_beat(OP_CLK_TICK, 16'h0000, 8'h00);
      send_beat(OP_RD_ICCS, 16'h0000, 8'h00);
      send_beat(OP_WR_ICCS, 16'h0000, 8'h00);
      send_beat(OP_UNUSED_LAST, 16'hFFFF, 8'hFF);
      drain();

      send_idle_pct  <= 26;
      recv_stall_pct <= 67;
      send_random(ITEMS_PER_PHASE);
      drain();

      write_halt_enable(1'b0);
      send_idle_pct  <= 67;
      recv_stall_pct <= 26;
      send_random(ITEMS_PER_PHASE);
      drain();

      write_halt_enable(1'b1);
      send_idle_pct  <= 0;
      recv_stall_pct <= 0;
      send_random(ITEMS_PER_PHASE);
      drain();

      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/ctr_pkg.sv
sv/ctr_core.sv
sv/console_terminal_registers.sv
sv/ctr_checker.sv
dv/console_terminal_registers_checker.sv
dv/console_terminal_registers_test.sv
